@@ rtl/core/body_velocity_integrator_defines.svh @@
// Assertion macros shared by the body velocity integrator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BODY_VELOCITY_INTEGRATOR_DEFINES_SVH
`define BODY_VELOCITY_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BVI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BVI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/bvi_pkg.sv @@
// Shared types, codes and helpers for the body velocity integrator.
// Depends on nothing; used by the controller, datapath and top level.
package bvi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_IMPULSE = 2'd1;
    localparam logic [1:0] OP_COLLIDE = 2'd2;

    localparam logic [2:0] REG_INV_MASS  = 3'd0;
    localparam logic [2:0] REG_DRAG      = 3'd1;
    localparam logic [2:0] REG_STATIC    = 3'd2;
    localparam logic [2:0] REG_ACTIVE    = 3'd3;
    localparam logic [2:0] REG_REFLECT   = 3'd4;
    localparam logic [2:0] REG_REST_SQ   = 3'd5;
    localparam logic [2:0] REG_MAX_SQ    = 3'd6;

    typedef struct packed {
        logic        [1:0]  op;
        logic        [20:0] dt;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               is_awake;
        logic               stepped;
    } out_word_t;

    // Multiply pass currently sequenced.
    typedef enum logic [2:0] {
        PH_DRAG = 3'd0,
        PH_SQ   = 3'd1,
        PH_POS  = 3'd2,
        PH_IMP  = 3'd3,
        PH_DOT  = 3'd4,
        PH_REFL = 3'd5
    } phase_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       use_p;
        logic       fin;
        logic       commit;
        phase_t     phase;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic run_tick;
        logic run_imp;
        logic run_refl;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] r;
        if (x > 68'sh7FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (x < -68'sh80000000)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/body_velocity_integrator.sv @@
// Top level of the body velocity integrator: controller plus datapath.
// Depends on bvi_pkg, bvi_ctrl and bvi_dp.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid/in_stall  | in_word  (bvi_pkg::in_word_t)
//   out     | output    | out_valid/out_stall| out_word (bvi_pkg::out_word_t)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An accepted word that does no work goes from load straight to commit; a tick,
// an impulse or a collision reflect runs its multiply passes through the single
// shared 33x33 multiplier, each product passing through a multiply state and a
// consume state. Reset is asynchronous; velocity, flags and registers go to
// their defaults. The input stalls while an item is in flight; a finished word
// waits in the output register under out_stall while the next item is accepted
// and run, and that item holds in its commit state until the register frees up.
// Config writes are taken every cycle (cfg_ready is tied high).
module body_velocity_integrator #(
    parameter int FRAC_BITS = bvi_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bvi_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output bvi_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    bvi_pkg::cmd_t    cmd;
    bvi_pkg::status_t status;

    // Writes land directly in the config registers, so never hold the config channel.
    assign cfg_ready = 1'b1;

    bvi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bvi_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_word)
    );

endmodule

@@ rtl/core/bvi_ctrl.sv @@
// Sequencer for the body velocity integrator: handshakes and multiply passes.
// Depends on bvi_pkg and body_velocity_integrator_defines.svh.
`include "body_velocity_integrator_defines.svh"

module bvi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bvi_pkg::status_t  status,
    output bvi_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_MUL    = 6'b000100,
        S_USE    = 6'b001000,
        S_FIN    = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    bvi_pkg::phase_t     phase_reg, phase_next;
    logic [1:0]          axis_reg, axis_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;
    logic                commit_go;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign commit_go = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                axis_next = 2'd0;
                if (status.run_tick)
                begin
                    phase_next = bvi_pkg::PH_DRAG;
                    state_next = S_MUL;
                end
                else if (status.run_imp)
                begin
                    phase_next = bvi_pkg::PH_IMP;
                    state_next = S_MUL;
                end
                else if (status.run_refl)
                begin
                    phase_next = bvi_pkg::PH_DOT;
                    state_next = S_MUL;
                end
                else
                    state_next = S_COMMIT;
            end
            S_MUL:
                state_next = S_USE;
            S_USE:
            begin
                if (axis_reg != 2'd2)
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL;
                end
                else
                begin
                    axis_next = 2'd0;
                    case (phase_reg)
                        bvi_pkg::PH_DRAG, bvi_pkg::PH_IMP:
                        begin
                            phase_next = bvi_pkg::PH_SQ;
                            state_next = S_MUL;
                        end
                        bvi_pkg::PH_SQ, bvi_pkg::PH_DOT:
                            state_next = S_FIN;
                        default:
                            state_next = S_COMMIT;
                    endcase
                end
            end
            S_FIN:
            begin
                if (phase_reg == bvi_pkg::PH_DOT)
                begin
                    phase_next = bvi_pkg::PH_REFL;
                    state_next = S_MUL;
                end
                else if (status.run_tick)
                begin
                    phase_next = bvi_pkg::PH_POS;
                    state_next = S_MUL;
                end
                else
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load   = accept;
        cmd.mul    = (state_reg == S_MUL);
        cmd.use_p  = (state_reg == S_USE);
        cmd.fin    = (state_reg == S_FIN);
        cmd.commit = commit_go;
        cmd.phase  = phase_reg;
        cmd.axis   = axis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= bvi_pkg::PH_DRAG;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BVI_ASSERT_IMP(a_axis_range, clk, rst_n, 1'b1, axis_reg != 2'd3)
    `BVI_ASSERT_NXT(a_accept_loads, clk, rst_n, accept, state_reg == S_LOAD)
    `BVI_ASSERT_IMP(a_valid_from_commit, clk, rst_n, $rose(out_valid_reg),
                    $past(state_reg) == S_COMMIT)

endmodule

@@ rtl/core/bvi_dp.sv @@
// Datapath for the body velocity integrator: state, config and shared multiplier.
// Depends on bvi_pkg; driven by bvi_ctrl through cmd_t.
module bvi_dp #(
    parameter int FRAC_BITS = bvi_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bvi_pkg::in_word_t  in_word,
    input  bvi_pkg::cmd_t      cmd,
    output bvi_pkg::status_t   status,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output bvi_pkg::out_word_t out_word
);

    localparam longint ONE_L    = longint'(1) << FRAC_BITS;
    localparam logic [31:0] INV_RST  = 32'(ONE_L / 2);
    localparam logic [16:0] DRAG_RST = 17'((ONE_L * 25) / 1000);
    localparam logic [31:0] REST_RST = 32'(((longint'(75) << FRAC_BITS) + 500000) / 1000000);
    localparam logic [31:0] MAX_RST  = 32'(ONE_L * 6);

    logic [31:0]        inv_mass_reg;
    logic [16:0]        drag_reg;
    logic               static_reg, active_reg, reflect_reg;
    logic [31:0]        rest_sq_reg, max_sq_reg;

    bvi_pkg::in_word_t  in_reg;
    bvi_pkg::out_word_t out_reg;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] w_reg   [3];
    logic signed [31:0] pos_reg [3];
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] d_reg;
    logic               awake_reg, coll_reg, ovf_reg, rest_reg;

    logic signed [31:0] vec_a [3];
    logic signed [31:0] pin_a [3];
    logic signed [31:0] vel_i, w_i, vec_i, pin_i;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [65:0] sh, shp1;
    logic signed [67:0] t_drag, t_pos, t_imp, t_refl;
    logic signed [65:0] sq;
    logic               run_coll;
    logic signed [31:0] vnew [3];
    logic               awake_new, coll_new;

    assign vec_a[0] = in_reg.vec_x;
    assign vec_a[1] = in_reg.vec_y;
    assign vec_a[2] = in_reg.vec_z;
    assign pin_a[0] = in_reg.pos_x;
    assign pin_a[1] = in_reg.pos_y;
    assign pin_a[2] = in_reg.pos_z;

    assign vel_i = vel_reg[cmd.axis];
    assign w_i   = w_reg[cmd.axis];
    assign vec_i = vec_a[cmd.axis];
    assign pin_i = pin_a[cmd.axis];

    assign status.run_tick = (in_reg.op == bvi_pkg::OP_TICK) && active_reg && awake_reg;
    assign status.run_imp  = (in_reg.op == bvi_pkg::OP_IMPULSE) && active_reg && !static_reg
                             && ((in_reg.vec_x != 32'sd0) || (in_reg.vec_y != 32'sd0)
                                 || (in_reg.vec_z != 32'sd0));
    assign run_coll        = (in_reg.op == bvi_pkg::OP_COLLIDE) && !coll_reg;
    assign status.run_refl = run_coll && reflect_reg;

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = 33'(vel_i);
        mul_b = 33'(w_i);
        case (cmd.phase)
            bvi_pkg::PH_DRAG:
            begin
                mul_a = 33'(vel_i);
                mul_b = $signed({16'd0, drag_reg});
            end
            bvi_pkg::PH_SQ:
            begin
                mul_a = 33'(w_i);
                mul_b = 33'(w_i);
            end
            bvi_pkg::PH_POS:
            begin
                mul_a = rest_reg ? 33'sd0 : (33'(vel_i) + 33'(w_i));
                mul_b = $signed({12'd0, in_reg.dt});
            end
            bvi_pkg::PH_IMP:
            begin
                mul_a = 33'(vec_i);
                mul_b = $signed({1'b0, inv_mass_reg});
            end
            bvi_pkg::PH_DOT:
            begin
                mul_a = 33'(vel_i);
                mul_b = 33'(vec_i);
            end
            bvi_pkg::PH_REFL:
            begin
                mul_a = 33'(vec_i);
                mul_b = 33'(d_reg);
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign sh     = prod_reg >>> FRAC_BITS;
    assign shp1   = prod_reg >>> (FRAC_BITS + 1);
    assign t_drag = 68'(vel_i) - 68'(sh);
    assign t_pos  = 68'(pin_i) + 68'(shp1);
    assign t_imp  = 68'(vel_i) + 68'(sh);
    assign t_refl = 68'(vel_i) - (68'(sh) <<< 1);
    assign sq     = acc_reg >>> FRAC_BITS;

    // Final state for the item.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            vnew[i] = vel_reg[i];
        awake_new = awake_reg;
        coll_new  = coll_reg;
        if (status.run_tick)
        begin
            for (int i = 0; i < 3; i++)
                vnew[i] = w_reg[i];
            awake_new = !rest_reg;
            coll_new  = 1'b0;
        end
        else if (status.run_imp)
        begin
            awake_new = 1'b1;
            if (!ovf_reg)
                for (int i = 0; i < 3; i++)
                    vnew[i] = w_reg[i];
        end
        else if (run_coll)
        begin
            coll_new = 1'b1;
            if (reflect_reg)
                for (int i = 0; i < 3; i++)
                    vnew[i] = w_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= INV_RST;
            drag_reg     <= DRAG_RST;
            static_reg   <= 1'b0;
            active_reg   <= 1'b1;
            reflect_reg  <= 1'b1;
            rest_sq_reg  <= REST_RST;
            max_sq_reg   <= MAX_RST;
            awake_reg    <= 1'b0;
            coll_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
                vel_reg[i] <= 32'sd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bvi_pkg::REG_INV_MASS: inv_mass_reg <= cfg_data;
                    bvi_pkg::REG_DRAG:     drag_reg     <= cfg_data[16:0];
                    bvi_pkg::REG_STATIC:   static_reg   <= cfg_data[0];
                    bvi_pkg::REG_ACTIVE:   active_reg   <= cfg_data[0];
                    bvi_pkg::REG_REFLECT:  reflect_reg  <= cfg_data[0];
                    bvi_pkg::REG_REST_SQ:  rest_sq_reg  <= cfg_data;
                    bvi_pkg::REG_MAX_SQ:   max_sq_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < 3; i++)
                    vel_reg[i] <= vnew[i];
                awake_reg <= awake_new;
                coll_reg  <= coll_new;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= in_word;
            ovf_reg  <= 1'b0;
            rest_reg <= 1'b0;
        end
        if (cmd.mul)
            prod_reg <= prod;
        if (cmd.use_p)
        begin
            case (cmd.phase)
                bvi_pkg::PH_DRAG: w_reg[cmd.axis] <= bvi_pkg::sat32(t_drag);
                bvi_pkg::PH_SQ:
                    acc_reg <= ((cmd.axis == 2'd0) ? 66'sd0 : acc_reg) + prod_reg;
                bvi_pkg::PH_POS:  pos_reg[cmd.axis] <= bvi_pkg::sat32(t_pos);
                bvi_pkg::PH_IMP:
                begin
                    w_reg[cmd.axis] <= t_imp[31:0];
                    if (t_imp != 68'($signed(t_imp[31:0])))
                        ovf_reg <= 1'b1;
                end
                bvi_pkg::PH_DOT:
                    acc_reg <= ((cmd.axis == 2'd0) ? 66'sd0 : acc_reg) + sh;
                bvi_pkg::PH_REFL: w_reg[cmd.axis] <= bvi_pkg::sat32(t_refl);
                default: ;
            endcase
        end
        if (cmd.fin)
        begin
            if (cmd.phase == bvi_pkg::PH_DOT)
                d_reg <= bvi_pkg::sat32(68'(acc_reg));
            else if (status.run_tick)
            begin
                if (sq <= $signed({34'd0, rest_sq_reg}))
                begin
                    rest_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                        w_reg[i] <= 32'sd0;
                end
            end
            else if (sq > $signed({34'd0, max_sq_reg}))
                ovf_reg <= 1'b1;
        end
        if (cmd.commit)
        begin
            out_reg.new_pos_x <= status.run_tick ? pos_reg[0] : in_reg.pos_x;
            out_reg.new_pos_y <= status.run_tick ? pos_reg[1] : in_reg.pos_y;
            out_reg.new_pos_z <= status.run_tick ? pos_reg[2] : in_reg.pos_z;
            out_reg.vel_x     <= vnew[0];
            out_reg.vel_y     <= vnew[1];
            out_reg.vel_z     <= vnew[2];
            out_reg.is_awake  <= awake_new;
            out_reg.stepped   <= status.run_tick;
        end
    end

    assign out_word = out_reg;

endmodule

@@ test/tb_body_velocity_integrator.sv @@
// Self-checking testbench for body_velocity_integrator: tick, impulse and collision words.
// Depends on bvi_pkg and the RTL of the block; an internal velocity model predicts each result.
module tb_body_velocity_integrator;

    localparam int  FB          = 16;
    localparam int  IDLE_LIMIT  = 5000;
    localparam int  SETTLE      = 40;
    localparam int  LONG_HOLD   = 400;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    bvi_pkg::in_word_t   in_word;
    logic                out_valid;
    logic                out_stall;
    bvi_pkg::out_word_t  out_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    body_velocity_integrator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Body model: registers, velocity and flags as the block should hold them.
    longint              m_inv_mass, m_drag, m_static, m_active, m_reflect;
    longint              m_rest_sq, m_max_sq;
    longint              body_vel[3];
    bit                  body_awake, body_collided;

    bvi_pkg::out_word_t  expected_words[$];
    int                  mismatches;
    int                  words_sent;
    int                  words_checked;
    int                  cfg_writes;
    int                  burst_left;
    int                  idle_cycles;
    bit                  hold_request;
    int                  hold_cnt;
    int                  stall_mode;

    always #5 clk = ~clk;

    function automatic longint sat32_l(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned speed_sq_of(longint a, longint b, longint c);
        longint unsigned ma, mb, mc;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        return (ma * ma + mb * mb + mc * mc) >> FB;
    endfunction

    // Advance the body model by one input word and return the word it should emit.
    function automatic bvi_pkg::out_word_t integrate_word(bvi_pkg::in_word_t w);
        longint    pos[3], vec[3], v[3], prev[3], nv[3];
        longint    dt, dot;
        bit        stepped, over;
        bvi_pkg::out_word_t r;
        dt = longint'(w.dt);
        pos[0] = longint'($signed(w.pos_x));
        pos[1] = longint'($signed(w.pos_y));
        pos[2] = longint'($signed(w.pos_z));
        vec[0] = longint'($signed(w.vec_x));
        vec[1] = longint'($signed(w.vec_y));
        vec[2] = longint'($signed(w.vec_z));
        v = body_vel;
        stepped = 0;
        case (w.op)
            bvi_pkg::OP_TICK: begin
                if (m_active != 0 && body_awake) begin
                    for (int i = 0; i < 3; i++)
                    begin
                        prev[i] = v[i];
                        v[i] = sat32_l(v[i] - ((v[i] * m_drag) >>> FB));
                    end
                    if (speed_sq_of(v[0], v[1], v[2]) <= longint'(m_rest_sq))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            v[i] = 0;
                            prev[i] = 0;
                        end
                        body_awake = 0;
                    end
                    for (int i = 0; i < 3; i++)
                        pos[i] = sat32_l(pos[i] + (((prev[i] + v[i]) * dt) >>> (FB + 1)));
                    body_collided = 0;
                    stepped = 1;
                end
            end
            bvi_pkg::OP_IMPULSE: begin
                if (m_active != 0 && m_static == 0 &&
                    (vec[0] != 0 || vec[1] != 0 || vec[2] != 0))
                begin
                    body_awake = 1;
                    over = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        nv[i] = v[i] + ((vec[i] * m_inv_mass) >>> FB);
                        if (nv[i] != sat32_l(nv[i]))
                            over = 1;
                    end
                    if (!over && speed_sq_of(nv[0], nv[1], nv[2]) > longint'(m_max_sq))
                        over = 1;
                    if (!over)
                        v = nv;
                end
            end
            bvi_pkg::OP_COLLIDE: begin
                if (!body_collided) begin
                    body_collided = 1;
                    if (m_reflect != 0) begin
                        dot = 0;
                        for (int i = 0; i < 3; i++)
                            dot += (v[i] * vec[i]) >>> FB;
                        dot = sat32_l(dot);
                        for (int i = 0; i < 3; i++)
                            v[i] = sat32_l(v[i] - 2 * ((vec[i] * dot) >>> FB));
                    end
                end
            end
            default: ;
        endcase
        body_vel = v;
        r.new_pos_x = pos[0][31:0];
        r.new_pos_y = pos[1][31:0];
        r.new_pos_z = pos[2][31:0];
        r.vel_x     = v[0][31:0];
        r.vel_y     = v[1][31:0];
        r.vel_z     = v[2][31:0];
        r.is_awake  = body_awake;
        r.stepped   = stepped;
        return r;
    endfunction

    // Value mix: full random for bit coverage, small magnitudes for real motion, extremes.
    function automatic logic [31:0] pick_s32(int small_mag);
        case ($urandom_range(0, 9))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3, 4:    return $urandom();
            default: return 32'($signed($urandom_range(0, 2 * small_mag)) - small_mag);
        endcase
    endfunction

    function automatic bvi_pkg::in_word_t make_word(logic [1:0] op, int mag);
        bvi_pkg::in_word_t w;
        w.op    = op;
        w.dt    = ($urandom_range(0, 7) == 0) ? 21'($urandom()) : 21'($urandom_range(0, 1048576));
        w.pos_x = pick_s32(1 << 24);
        w.pos_y = pick_s32(1 << 24);
        w.pos_z = pick_s32(1 << 24);
        w.vec_x = pick_s32(mag);
        w.vec_y = pick_s32(mag);
        w.vec_z = pick_s32(mag);
        return w;
    endfunction

    // Offer one word in bursts with random gaps; return just after the accepting edge.
    task automatic send_word(bvi_pkg::in_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        expected_words.push_back(integrate_word(w));
        words_sent++;
        burst_left--;
    endtask

    // Hold the input idle until every result is back, then let the pipeline settle.
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Offer one register write and leave valid up; the caller drops it.
    task automatic put_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
        case (idx)
            bvi_pkg::REG_INV_MASS: m_inv_mass = longint'(data);
            bvi_pkg::REG_DRAG:     m_drag     = longint'(data[16:0]);
            bvi_pkg::REG_STATIC:   m_static   = longint'(data[0]);
            bvi_pkg::REG_ACTIVE:   m_active   = longint'(data[0]);
            bvi_pkg::REG_REFLECT:  m_reflect  = longint'(data[0]);
            bvi_pkg::REG_REST_SQ:  m_rest_sq  = longint'(data);
            bvi_pkg::REG_MAX_SQ:   m_max_sq   = longint'(data);
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        put_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] inv, logic [31:0] drag, bit stat, bit act,
                             bit refl, logic [31:0] rest, logic [31:0] maxsq);
        put_reg(bvi_pkg::REG_INV_MASS, inv);
        put_reg(bvi_pkg::REG_DRAG, drag);
        put_reg(bvi_pkg::REG_STATIC, 32'(stat));
        put_reg(bvi_pkg::REG_ACTIVE, 32'(act));
        put_reg(bvi_pkg::REG_REFLECT, 32'(refl));
        put_reg(bvi_pkg::REG_REST_SQ, rest);
        put_reg(bvi_pkg::REG_MAX_SQ, maxsq);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_fields(logic [1:0] op, logic [20:0] dt, logic [31:0] p,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        bvi_pkg::in_word_t w;
        w.op = op;
        w.dt = dt;
        w.pos_x = p;
        w.pos_y = ~p;
        w.pos_z = p ^ 32'h5A5A5A5A;
        w.vec_x = vx;
        w.vec_y = vy;
        w.vec_z = vz;
        send_word(w);
    endtask

    // Directed words: asleep tick, unused op, zero impulse, wake, drag, rest, collision, saturation.
    task automatic test_directed;
        send_fields(bvi_pkg::OP_TICK, 21'd65536, 32'h00010000, 0, 0, 0);
        send_fields(OP_NONE, 21'h1FFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 1);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 0, 0, 0);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 32'h00020000, 32'hFFFF0000,
                    32'h00008000);
        send_fields(bvi_pkg::OP_TICK, 21'd65536, 32'h00100000, 0, 0, 0);
        send_fields(bvi_pkg::OP_TICK, 21'd1048576, 32'h7FFFFFF0, 0, 0, 0);
        send_fields(bvi_pkg::OP_TICK, 21'h1FFFFF, 32'h80000010, 0, 0, 0);
        send_fields(bvi_pkg::OP_COLLIDE, 21'd0, 32'h0, 32'h00010000, 0, 0);
        send_fields(bvi_pkg::OP_COLLIDE, 21'd0, 32'h0, 0, 32'h00010000, 0);
        send_fields(bvi_pkg::OP_TICK, 21'd4096, 32'h0, 0, 0, 0);
        send_fields(bvi_pkg::OP_COLLIDE, 21'd0, 32'h0, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 32'h00100000, 0, 0);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 32'h00000100, 32'h00000100,
                    32'h00000100);
        drain();
        // Drag at one and above one, and the maximum inverse mass.
        write_all(32'hFFFFFFFF, 32'h0001FFFF, 0, 1, 1, 32'd0, 32'hFFFFFFFF);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 32'h00007FFF, 32'hFFFF8000,
                    32'h00001000);
        send_fields(bvi_pkg::OP_TICK, 21'd65536, 32'h0, 0, 0, 0);
        send_fields(bvi_pkg::OP_TICK, 21'd65536, 32'h0, 0, 0, 0);
        drain();
        write_reg(bvi_pkg::REG_DRAG, 32'd65536);
        send_fields(bvi_pkg::OP_IMPULSE, 21'd0, 32'h0, 32'h00010000, 0, 0);
        send_fields(bvi_pkg::OP_TICK, 21'd65536, 32'h0, 0, 0, 0);
        drain();
        // An index beyond the register list must change nothing.
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        send_fields(OP_NONE, 21'd0, 32'h12345678, 0, 0, 0);
        drain();
    endtask

    // Short bursts under each corner setting: static, inactive, reflect off, limits.
    task automatic test_config_corners;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: write_all(32'd32768, 32'd1638, 1, 1, 1, 32'd5, 32'd393216);
                1: write_all(32'd32768, 32'd1638, 0, 0, 1, 32'd5, 32'd393216);
                2: write_all(32'd0, 32'd0, 0, 1, 0, 32'd0, 32'd0);
                3: write_all(32'd65536, 32'd0, 0, 1, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
                4: write_all(32'd65536, 32'd65536, 0, 1, 1, 32'd0, 32'hFFFFFFFF);
                default: write_all(32'd32768, 32'd1638, 0, 1, 1, 32'd5, 32'd393216);
            endcase
            for (int n = 0; n < 12; n++)
                send_word(make_word(logic'(n % 4 == 3) ? bvi_pkg::OP_COLLIDE : 2'(n % 2),
                                    1 << 18));
            drain();
        end
    endtask

    // Random phases: a random mix of impulses, ticks and collisions, with some noise words.
    task automatic test_random;
        logic [1:0] op;
        int         r;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_all(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 131072),
                      ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 8192),
                      ($urandom_range(0, 5) == 0), ($urandom_range(0, 7) != 0),
                      ($urandom_range(0, 3) != 0),
                      ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 64),
                      ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1 << 22));
            for (int n = 0; n < 400; n++)
            begin
                r = $urandom_range(0, 19);
                if (r < 4)
                    op = bvi_pkg::OP_IMPULSE;
                else if (r < 15)
                    op = bvi_pkg::OP_TICK;
                else if (r < 18)
                    op = bvi_pkg::OP_COLLIDE;
                else
                    op = 2'($urandom());
                send_word(make_word(op, (op == bvi_pkg::OP_COLLIDE) ? 65536 : (1 << 18)));
            end
            drain();
        end
    endtask

    // Hold the receiver off so the block backs up, then pause the sender until empty.
    task automatic test_backpressure;
        write_all(32'd32768, 32'd1638, 0, 1, 1, 32'd5, 32'd393216);
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++)
            send_word(make_word(2'(n % 3), 1 << 18));
        drain();
    endtask

    // Receiver stall pattern, with an occasional long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            hold_cnt   = 0;
            stall_mode = 0;
        end else begin
            if (hold_request) begin
                hold_cnt = LONG_HOLD;
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 149) == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest prediction, field by field.
    always @(posedge clk)
    begin
        bvi_pkg::out_word_t exp_w;
        bit                 bad;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", out_word);
            end else begin
                exp_w = expected_words.pop_front();
                words_checked++;
                bad = (out_word.new_pos_x !== exp_w.new_pos_x) ||
                      (out_word.new_pos_y !== exp_w.new_pos_y) ||
                      (out_word.new_pos_z !== exp_w.new_pos_z) ||
                      (out_word.vel_x     !== exp_w.vel_x)     ||
                      (out_word.vel_y     !== exp_w.vel_y)     ||
                      (out_word.vel_z     !== exp_w.vel_z)     ||
                      (out_word.is_awake  !== exp_w.is_awake)  ||
                      (out_word.stepped   !== exp_w.stepped);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch word %0d: exp pos %h %h %h vel %h %h %h aw %b st %b,",
                                  " got pos %h %h %h vel %h %h %h aw %b st %b"},
                                 words_checked,
                                 exp_w.new_pos_x, exp_w.new_pos_y, exp_w.new_pos_z,
                                 exp_w.vel_x, exp_w.vel_y, exp_w.vel_z,
                                 exp_w.is_awake, exp_w.stepped,
                                 out_word.new_pos_x, out_word.new_pos_y, out_word.new_pos_z,
                                 out_word.vel_x, out_word.vel_y, out_word.vel_z,
                                 out_word.is_awake, out_word.stepped);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no handshake anywhere.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_stall = 1'b0;
        hold_request = 1'b0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        cfg_writes = 0;
        burst_left = 0;
        idle_cycles = 0;
        m_inv_mass = 32768;
        m_drag = 1638;
        m_static = 0;
        m_active = 1;
        m_reflect = 1;
        m_rest_sq = 5;
        m_max_sq = 393216;
        body_vel = '{0, 0, 0};
        body_awake = 0;
        body_collided = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_corners();
        test_random();
        test_backpressure();

        if (expected_words.size() != 0)
            mismatches += expected_words.size();
        $display("covered %0d words and %0d register writes; %0d results checked",
                 words_sent, cfg_writes, words_checked);
        $display("phases: directed corners, config corners, random motion, long output hold-off");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bvi_pkg.sv
rtl/core/bvi_ctrl.sv
rtl/core/bvi_dp.sv
rtl/core/body_velocity_integrator.sv
test/tb_body_velocity_integrator.sv
